// File: sv/hrp_pkg.sv
// types, constants and character helpers for the http request parser
`default_nettype none

package hrp_pkg;

   localparam int DEF_LENGTH_BITS = 32;
   localparam logic [31:0] MAX_BODY_RESET = 32'(16 * 1024 * 1024);
   localparam logic [3:0] NAME_LEN = 4'd14;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_DEL   = 8'd127;
   localparam logic [7:0] CH_CTL_MAX = 8'd31;

   localparam logic [1:0] STATUS_PENDING   = 2'd0;
   localparam logic [1:0] STATUS_COMPLETE  = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED = 2'd2;

   localparam logic [2:0] CLASS_DELIM  = 3'd0;
   localparam logic [2:0] CLASS_METHOD = 3'd1;
   localparam logic [2:0] CLASS_URI    = 3'd2;
   localparam logic [2:0] CLASS_NAME   = 3'd3;
   localparam logic [2:0] CLASS_VALUE  = 3'd4;
   localparam logic [2:0] CLASS_BODY   = 3'd5;

   typedef enum logic [4:0] {
      ST_METHOD_START, ST_METHOD, ST_URI, ST_VH, ST_VT1, ST_VT2, ST_VP, ST_VSLASH,
      ST_MAJ_START, ST_MAJ, ST_MIN_START, ST_MIN, ST_NL1, ST_LINE_START, ST_LWS,
      ST_NAME, ST_SP_VALUE, ST_VALUE, ST_NL2, ST_NL3, ST_BODY
   } parse_state_type;

   typedef enum logic [1:0] {
      LEN_SKIP, LEN_DIGITS, LEN_DONE
   } len_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_request;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  parse_status;
      logic [2:0]  byte_class;
      logic [7:0]  out_byte;
      logic        header_start;
      logic [15:0] version_major;
      logic [15:0] version_minor;
      logic [31:0] body_length;
   } rsp_payload_type;

   function automatic logic is_ctl(input logic [7:0] c);
      return (c <= CH_CTL_MAX) || (c == CH_DEL);
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_tsp(input logic [7:0] c);
      logic r;
      r = 1'b0;
      case (c) inside
         "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
         "=", "{", "}", CH_SP, CH_TAB: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_token(input logic [7:0] c);
      return !c[7] && !is_ctl(c) && !is_tsp(c);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
   endfunction

   // acc * 10 + digit, saturating at 16 bits
   function automatic logic [15:0] ver_add(input logic [15:0] acc, input logic [7:0] c);
      logic [19:0] prod;
      prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, c[3:0]};
      return (prod[19:16] != 4'b0) ? 16'hffff : prod[15:0];
   endfunction

   // lowercase "content-length"
   function automatic logic [7:0] cl_char(input logic [3:0] pos);
      logic [7:0] r;
      r = 8'h00;
      unique case (pos)
         4'd0:  r = "c";
         4'd1:  r = "o";
         4'd2:  r = "n";
         4'd3:  r = "t";
         4'd4:  r = "e";
         4'd5:  r = "n";
         4'd6:  r = "t";
         4'd7:  r = "-";
         4'd8:  r = "l";
         4'd9:  r = "e";
         4'd10: r = "n";
         4'd11: r = "g";
         4'd12: r = "t";
         4'd13: r = "h";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/hrp_engine.sv
// per-request parse state and the combinational byte step
`default_nettype none

module hrp_engine #(
   parameter int LENGTH_BITS = hrp_pkg::DEF_LENGTH_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire hrp_pkg::req_payload_type item,
   input  wire logic [31:0]              max_body_len,
   output hrp_pkg::rsp_payload_type      result
);
   import hrp_pkg::*;

   parse_state_type         state_ff, state_in, cur_state;
   logic [15:0]             major_ff, major_in, cur_major;
   logic [15:0]             minor_ff, minor_in, cur_minor;
   logic [LENGTH_BITS-1:0]  remain_ff, remain_in, cur_remain, remain_dec;
   logic [LENGTH_BITS-1:0]  lacc_ff, lacc_in, cur_lacc;
   logic [3:0]              pos_ff, pos_in, cur_pos;
   logic                    mism_ff, mism_in, cur_mism;
   logic                    seen_ff, seen_in, cur_seen;
   logic                    inlen_ff, inlen_in, cur_inlen;
   len_phase_type           phase_ff, phase_in, cur_phase;
   logic                    neg_ff, neg_in, cur_neg;
   logic                    anyh_ff, anyh_in, cur_anyh;
   logic                    taken_ff, taken_in, cur_taken;
   logic [1:0]              final_ff, final_in, cur_final;

   logic [7:0]              c, lc;
   logic [2:0]              cls;
   logic [7:0]              ob;
   logic                    hs, bad;
   logic [LENGTH_BITS+3:0]  len_prod;
   logic [LENGTH_BITS-1:0]  len_sat;
   logic [LENGTH_BITS-1:0]  upd_lacc;
   len_phase_type           upd_phase;
   logic                    upd_neg;
   logic [LENGTH_BITS+31:0] lacc_ext, max_ext;
   logic [LENGTH_BITS+31:0] body_ext;

   assign c  = item.data_byte;
   assign lc = to_lower(c);

   // current state, cleared when a new request starts with this byte
   always_comb begin
      if (item.new_request) begin
         cur_state  = ST_METHOD_START;
         cur_major  = '0;
         cur_minor  = '0;
         cur_remain = '0;
         cur_lacc   = '0;
         cur_pos    = '0;
         cur_mism   = 1'b0;
         cur_seen   = 1'b0;
         cur_inlen  = 1'b0;
         cur_phase  = LEN_SKIP;
         cur_neg    = 1'b0;
         cur_anyh   = 1'b0;
         cur_taken  = 1'b0;
         cur_final  = STATUS_PENDING;
      end else begin
         cur_state  = state_ff;
         cur_major  = major_ff;
         cur_minor  = minor_ff;
         cur_remain = remain_ff;
         cur_lacc   = lacc_ff;
         cur_pos    = pos_ff;
         cur_mism   = mism_ff;
         cur_seen   = seen_ff;
         cur_inlen  = inlen_ff;
         cur_phase  = phase_ff;
         cur_neg    = neg_ff;
         cur_anyh   = anyh_ff;
         cur_taken  = taken_ff;
         cur_final  = final_ff;
      end
   end

   // content-length value digit step
   assign len_prod = ({4'b0, cur_lacc} << 3) + ({4'b0, cur_lacc} << 1)
                     + {{LENGTH_BITS{1'b0}}, c[3:0]};
   assign len_sat  = (len_prod[LENGTH_BITS+3 -: 4] != 4'b0) ? '1 : len_prod[LENGTH_BITS-1:0];

   always_comb begin
      upd_lacc  = cur_lacc;
      upd_phase = cur_phase;
      upd_neg   = cur_neg;
      if (cur_inlen && (cur_phase == LEN_SKIP || cur_phase == LEN_DIGITS)) begin
         if (cur_phase == LEN_SKIP && c == CH_SP) begin
            upd_phase = LEN_SKIP;
         end else if (cur_phase == LEN_SKIP && (c == "+" || c == "-")) begin
            upd_neg   = (c == "-");
            upd_phase = LEN_DIGITS;
         end else if (is_dig(c)) begin
            upd_lacc  = len_sat;
            upd_phase = LEN_DIGITS;
         end else begin
            upd_phase = LEN_DONE;
         end
      end
   end

   assign lacc_ext   = {32'b0, cur_lacc};
   assign max_ext    = {{LENGTH_BITS{1'b0}}, max_body_len};
   assign remain_dec = (cur_remain != '0) ? cur_remain - 1'b1 : cur_remain;

   always_comb begin
      state_in  = cur_state;
      major_in  = cur_major;
      minor_in  = cur_minor;
      remain_in = cur_remain;
      lacc_in   = cur_lacc;
      pos_in    = cur_pos;
      mism_in   = cur_mism;
      seen_in   = cur_seen;
      inlen_in  = cur_inlen;
      phase_in  = cur_phase;
      neg_in    = cur_neg;
      anyh_in   = cur_anyh;
      taken_in  = cur_taken;
      final_in  = cur_final;
      cls       = CLASS_DELIM;
      ob        = c;
      hs        = 1'b0;
      bad       = 1'b0;
      if (cur_final == STATUS_PENDING) begin
         unique case (cur_state)
            ST_METHOD_START: begin
               if (!is_token(c)) bad = 1'b1;
               else begin
                  state_in = ST_METHOD;
                  cls      = CLASS_METHOD;
               end
            end
            ST_METHOD: begin
               if (c == CH_SP) state_in = ST_URI;
               else if (!is_token(c)) bad = 1'b1;
               else cls = CLASS_METHOD;
            end
            ST_URI: begin
               if (c == CH_SP) state_in = ST_VH;
               else if (is_ctl(c)) bad = 1'b1;
               else cls = CLASS_URI;
            end
            ST_VH: begin
               if (c == "H") state_in = ST_VT1;
               else bad = 1'b1;
            end
            ST_VT1: begin
               if (c == "T") state_in = ST_VT2;
               else bad = 1'b1;
            end
            ST_VT2: begin
               if (c == "T") state_in = ST_VP;
               else bad = 1'b1;
            end
            ST_VP: begin
               if (c == "P") state_in = ST_VSLASH;
               else bad = 1'b1;
            end
            ST_VSLASH: begin
               if (c == "/") begin
                  major_in = '0;
                  minor_in = '0;
                  state_in = ST_MAJ_START;
               end else bad = 1'b1;
            end
            ST_MAJ_START: begin
               if (is_dig(c)) begin
                  major_in = ver_add(cur_major, c);
                  state_in = ST_MAJ;
               end else bad = 1'b1;
            end
            ST_MAJ: begin
               if (c == ".") state_in = ST_MIN_START;
               else if (is_dig(c)) major_in = ver_add(cur_major, c);
               else bad = 1'b1;
            end
            ST_MIN_START: begin
               if (is_dig(c)) begin
                  minor_in = ver_add(cur_minor, c);
                  state_in = ST_MIN;
               end else bad = 1'b1;
            end
            ST_MIN: begin
               if (c == CH_CR) state_in = ST_NL1;
               else if (is_dig(c)) minor_in = ver_add(cur_minor, c);
               else bad = 1'b1;
            end
            ST_NL1: begin
               if (c == CH_LF) state_in = ST_LINE_START;
               else bad = 1'b1;
            end
            ST_LINE_START: begin
               if (c == CH_CR) state_in = ST_NL3;
               else if (cur_anyh && (c == CH_SP || c == CH_TAB)) state_in = ST_LWS;
               else if (!is_token(c)) bad = 1'b1;
               else begin
                  anyh_in  = 1'b1;
                  inlen_in = 1'b0;
                  pos_in   = (lc == cl_char(4'd0)) ? 4'd1 : 4'd0;
                  mism_in  = (lc != cl_char(4'd0));
                  ob       = lc;
                  cls      = CLASS_NAME;
                  hs       = 1'b1;
                  state_in = ST_NAME;
               end
            end
            ST_LWS: begin
               if (c == CH_CR) state_in = ST_NL2;
               else if (c == CH_SP || c == CH_TAB) state_in = ST_LWS;
               else if (is_ctl(c)) bad = 1'b1;
               else begin
                  state_in = ST_VALUE;
                  cls      = CLASS_VALUE;
                  lacc_in  = upd_lacc;
                  phase_in = upd_phase;
                  neg_in   = upd_neg;
               end
            end
            ST_NAME: begin
               if (c == ":") begin
                  if (!cur_mism && cur_pos == NAME_LEN && !cur_seen) begin
                     seen_in  = 1'b1;
                     inlen_in = 1'b1;
                     phase_in = LEN_SKIP;
                     neg_in   = 1'b0;
                     lacc_in  = '0;
                  end
                  state_in = ST_SP_VALUE;
               end else if (!is_token(c)) bad = 1'b1;
               else begin
                  ob  = lc;
                  cls = CLASS_NAME;
                  if (cur_mism || cur_pos >= NAME_LEN) mism_in = 1'b1;
                  else if (lc == cl_char(cur_pos)) pos_in = cur_pos + 4'd1;
                  else mism_in = 1'b1;
               end
            end
            ST_SP_VALUE: begin
               if (c == CH_SP) state_in = ST_VALUE;
               else bad = 1'b1;
            end
            ST_VALUE: begin
               if (c == CH_CR) state_in = ST_NL2;
               else if (is_ctl(c)) bad = 1'b1;
               else begin
                  cls      = CLASS_VALUE;
                  lacc_in  = upd_lacc;
                  phase_in = upd_phase;
                  neg_in   = upd_neg;
               end
            end
            ST_NL2: begin
               if (c == CH_LF) state_in = ST_LINE_START;
               else bad = 1'b1;
            end
            ST_NL3: begin
               if (c != CH_LF) bad = 1'b1;
               else begin
                  inlen_in = 1'b0;
                  if (cur_seen && !cur_neg && cur_lacc != '0) begin
                     if (lacc_ext > max_ext) bad = 1'b1;
                     else begin
                        remain_in = cur_lacc;
                        taken_in  = 1'b1;
                        state_in  = ST_BODY;
                     end
                  end else begin
                     final_in = STATUS_COMPLETE;
                  end
               end
            end
            ST_BODY: begin
               cls       = CLASS_BODY;
               remain_in = remain_dec;
               if (remain_dec == '0) final_in = STATUS_COMPLETE;
            end
            default: bad = 1'b1;
         endcase
         if (bad) begin
            final_in = STATUS_MALFORMED;
            cls      = CLASS_DELIM;
            ob       = c;
            hs       = 1'b0;
         end
      end
   end

   assign body_ext = {32'b0, lacc_in};

   always_comb begin
      result.parse_status  = final_in;
      result.byte_class    = cls;
      result.out_byte      = ob;
      result.header_start  = hs;
      result.version_major = major_in;
      result.version_minor = minor_in;
      result.body_length   = taken_in ? body_ext[31:0] : 32'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_METHOD_START;
         major_ff  <= '0;
         minor_ff  <= '0;
         remain_ff <= '0;
         lacc_ff   <= '0;
         pos_ff    <= '0;
         mism_ff   <= 1'b0;
         seen_ff   <= 1'b0;
         inlen_ff  <= 1'b0;
         phase_ff  <= LEN_SKIP;
         neg_ff    <= 1'b0;
         anyh_ff   <= 1'b0;
         taken_ff  <= 1'b0;
         final_ff  <= STATUS_PENDING;
      end else if (step) begin
         state_ff  <= state_in;
         major_ff  <= major_in;
         minor_ff  <= minor_in;
         remain_ff <= remain_in;
         lacc_ff   <= lacc_in;
         pos_ff    <= pos_in;
         mism_ff   <= mism_in;
         seen_ff   <= seen_in;
         inlen_ff  <= inlen_in;
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         anyh_ff   <= anyh_in;
         taken_ff  <= taken_in;
         final_ff  <= final_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/http_request_parser.sv
// top level of the http request parser: handshake, input and result registers
`default_nettype none

// Checks an HTTP request one byte per transfer and returns one result per
// byte: status (pending, complete, malformed), byte class, the byte with header
// names lowercased, a header start flag, version numbers and the accepted body
// length. A byte is taken every cycle while rsp_ready stays high; its result
// passes first through the input register and then through the result register.
// The whole per-byte state update is one pass of logic between those two
// registers, so throughput is one byte per clock while rsp_ready stays high.
// Set new_request on the first byte of each request; complete and malformed
// stay until then. csr_wr_en/csr_wr_data load max_body_len (reset 16 MiB).
module http_request_parser #(
   parameter int LENGTH_BITS = hrp_pkg::DEF_LENGTH_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire hrp_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output hrp_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                     csr_wr_en,
   input  wire logic [31:0]              csr_wr_data
);
   import hrp_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   logic [31:0]     max_body_ff;
   logic            advance, accept;
   rsp_payload_type step_result;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   hrp_engine #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .item         (in_data_ff),
      .max_body_len (max_body_ff),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_body_ff  <= MAX_BODY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) max_body_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_data_ff <= req_payload;
      if (advance) rsp_data_ff <= step_result;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // a held byte is never dropped
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input byte lost while stalled");

   a_malformed_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.parse_status == STATUS_MALFORMED |->
      rsp_data_ff.byte_class == CLASS_DELIM && !rsp_data_ff.header_start)
      else $error("malformed result carries a class");

   a_header_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.header_start |->
      rsp_data_ff.byte_class == CLASS_NAME)
      else $error("header start outside a header name");

   a_body_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.body_length != 32'b0 |->
      rsp_data_ff.parse_status != STATUS_MALFORMED)
      else $error("body length reported on a malformed request");

endmodule

`default_nettype wire
